// ----- src/mkpc_pkg.sv -----
// Shared types, constants and register indexes for the motor kickstart power control core.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package mkpc_pkg;

   localparam int LEVEL_W    = 8;
   localparam int KICK_W     = 13;
   localparam int RUN_W      = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_POWER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_POWER  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KICK_POWER = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KICK_MS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RUN_MS = 3'd4;

   localparam logic MODE_REQUEST = 1'b0;
   localparam logic MODE_TICK    = 1'b1;

   localparam logic [LEVEL_W-1:0] MIN_POWER_RST  = 8'd1;
   localparam logic [LEVEL_W-1:0] MAX_POWER_RST  = 8'd255;
   localparam logic [LEVEL_W-1:0] KICK_POWER_RST = 8'd255;
   localparam logic [KICK_W-1:0]  KICK_MS_RST    = 13'd100;
   localparam logic [RUN_W-1:0]   MAX_RUN_MS_RST = 31'd300000;

   localparam logic [KICK_W-1:0] KICK_MAX = '1;
   localparam logic [RUN_W-1:0]  RUN_MAX  = '1;

   typedef struct packed {
      logic [LEVEL_W-1:0] min_power;
      logic [LEVEL_W-1:0] max_power;
      logic [LEVEL_W-1:0] kick_power;
      logic [KICK_W-1:0]  kick_duration_ms;
      logic [RUN_W-1:0]   max_run_ms;
   } cfg_type;

   typedef struct packed {
      logic               mode;
      logic [LEVEL_W-1:0] level;
   } stage_type;

endpackage

`default_nettype wire

// ----- src/mkpc_if.sv -----
// Valid/ready channel interfaces for requests and responses of the power control core.
// Depends on mkpc_pkg for field widths.
`default_nettype none

interface mkpc_req_if
   import mkpc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [LEVEL_W-1:0] request;

   modport source (output valid, output mode, output request, input ready);
   modport sink (input valid, input mode, input request, output ready);
endinterface

interface mkpc_rsp_if
   import mkpc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] drive_level;
   logic               drive_written;
   logic               locked_off;

   modport source (output valid, output drive_level, output drive_written, output locked_off,
                   input ready);
   modport sink (input valid, input drive_level, input drive_written, input locked_off,
                 output ready);
endinterface

`default_nettype wire

// ----- src/mkpc_csr.sv -----
// Configuration register file of the power control core, written through a plain write port.
// Depends on mkpc_pkg for the register indexes, reset values and the cfg_type struct.
`default_nettype none

module mkpc_csr
   import mkpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_MIN_POWER:  cfg_in.min_power        = wr_data[LEVEL_W-1:0];
            REG_MAX_POWER:  cfg_in.max_power        = wr_data[LEVEL_W-1:0];
            REG_KICK_POWER: cfg_in.kick_power       = wr_data[LEVEL_W-1:0];
            REG_KICK_MS:    cfg_in.kick_duration_ms = wr_data[KICK_W-1:0];
            REG_MAX_RUN_MS: cfg_in.max_run_ms       = wr_data[RUN_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_power        <= MIN_POWER_RST;
         cfg_ff.max_power        <= MAX_POWER_RST;
         cfg_ff.kick_power       <= KICK_POWER_RST;
         cfg_ff.kick_duration_ms <= KICK_MS_RST;
         cfg_ff.max_run_ms       <= MAX_RUN_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- src/mkpc_map.sv -----
// Input register and request mapping stage: puts a nonzero request in min..max; 0 stays 0.
// Depends on mkpc_pkg and mkpc_req_if; feeds mkpc_ctrl through a stage_type register.
`default_nettype none

module mkpc_map
   import mkpc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire cfg_type cfg,
   mkpc_req_if.sink    req_chan,
   output logic        out_valid,
   input  wire logic   out_ready,
   output stage_type   out_data
);

   logic               in_vld_ff;
   logic               in_mode_ff;
   logic [LEVEL_W-1:0] in_req_ff;
   logic               map_vld_ff;
   stage_type          map_data_ff;
   stage_type          map_data_in;

   logic               map_ready;
   logic               in_ready;
   logic [LEVEL_W-1:0] range;
   logic [2*LEVEL_W-1:0] product;
   logic [2*LEVEL_W:0]   scaled;
   logic [LEVEL_W-1:0] quotient;
   logic [LEVEL_W:0]   sum;
   logic [LEVEL_W-1:0] mapped;

   assign map_ready      = !map_vld_ff || out_ready;
   assign in_ready       = !in_vld_ff || map_ready;
   assign req_chan.ready = in_ready;

   // Division by 255 is exact here as (x + (x >> 8) + 1) >> 8 for x up to 255 * 255.
   always_comb begin
      range    = (cfg.max_power >= cfg.min_power) ? (cfg.max_power - cfg.min_power)
                                                  : (cfg.min_power - cfg.max_power);
      product  = range * in_req_ff;
      scaled   = {1'b0, product} + {{(LEVEL_W+1){1'b0}}, product[2*LEVEL_W-1:LEVEL_W]}
                 + {{(2*LEVEL_W){1'b0}}, 1'b1};
      quotient = scaled[2*LEVEL_W-1:LEVEL_W];
      sum      = {1'b0, cfg.min_power} + {1'b0, quotient};
      if (in_req_ff == '0) begin
         mapped = '0;
      end else if (sum < {1'b0, cfg.min_power}) begin
         mapped = cfg.min_power;
      end else if (sum > {1'b0, cfg.max_power}) begin
         mapped = cfg.max_power;
      end else begin
         mapped = sum[LEVEL_W-1:0];
      end
      map_data_in.mode  = in_mode_ff;
      map_data_in.level = mapped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         map_vld_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_vld_ff <= req_chan.valid;
         end
         if (map_ready) begin
            map_vld_ff <= in_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_mode_ff <= req_chan.mode;
         in_req_ff  <= req_chan.request;
      end
      if (map_ready && in_vld_ff) begin
         map_data_ff <= map_data_in;
      end
   end

   assign out_valid = map_vld_ff;
   assign out_data  = map_data_ff;

endmodule

`default_nettype wire

// ----- src/mkpc_ctrl.sv -----
// Motor state update: kick timer, run timer, lockout and the result register.
// Depends on mkpc_pkg and mkpc_rsp_if; takes mapped items from mkpc_map.
`default_nettype none

module mkpc_ctrl
   import mkpc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire cfg_type cfg,
   input  wire logic   in_valid,
   output logic        in_ready,
   input  wire stage_type in_data,
   mkpc_rsp_if.source  rsp_chan
);

   logic [LEVEL_W-1:0] cur_level_ff, cur_level_in;
   logic [LEVEL_W-1:0] tgt_level_ff, tgt_level_in;
   logic               kick_ff, kick_in;
   logic               lock_ff, lock_in;
   logic [KICK_W-1:0]  kick_cnt_ff, kick_cnt_in;
   logic [RUN_W-1:0]   run_cnt_ff, run_cnt_in;
   logic               written_in;

   logic               rsp_vld_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;
   logic               rsp_written_ff;
   logic               rsp_locked_ff;

   logic               xfer;
   logic [LEVEL_W-1:0] p;

   assign in_ready = !rsp_vld_ff || rsp_chan.ready;
   assign xfer     = in_valid && in_ready;
   assign p        = in_data.level;

   always_comb begin
      cur_level_in = cur_level_ff;
      tgt_level_in = tgt_level_ff;
      kick_in      = kick_ff;
      lock_in      = lock_ff;
      kick_cnt_in  = kick_cnt_ff;
      run_cnt_in   = run_cnt_ff;
      written_in   = 1'b0;
      if (in_data.mode == MODE_TICK) begin
         if (kick_in) begin
            if (kick_cnt_in != KICK_MAX) begin
               kick_cnt_in = kick_cnt_in + 1'b1;
            end
            if (kick_cnt_in >= cfg.kick_duration_ms) begin
               kick_in      = 1'b0;
               cur_level_in = tgt_level_in;
               written_in   = 1'b1;
            end
         end
         if (cur_level_in != '0 && cfg.max_run_ms != '0) begin
            if (run_cnt_in != RUN_MAX) begin
               run_cnt_in = run_cnt_in + 1'b1;
            end
            if (run_cnt_in >= cfg.max_run_ms) begin
               kick_in      = 1'b0;
               cur_level_in = '0;
               tgt_level_in = '0;
               lock_in      = 1'b1;
               written_in   = 1'b1;
            end
         end
      end else begin
         if (p == '0) begin
            lock_in = 1'b0;
         end
         if (!lock_in) begin
            if (cur_level_in == '0) begin
               if (p != '0) begin
                  run_cnt_in = '0;
                  if (cfg.kick_duration_ms != '0 && cfg.kick_power != '0 &&
                      p <= cfg.kick_power) begin
                     tgt_level_in = p;
                     if (!kick_in) begin
                        cur_level_in = cfg.kick_power;
                        kick_in      = 1'b1;
                        kick_cnt_in  = '0;
                        written_in   = 1'b1;
                     end
                  end else begin
                     cur_level_in = p;
                     tgt_level_in = p;
                     kick_in      = 1'b0;
                     written_in   = 1'b1;
                  end
               end
            end else if (kick_in) begin
               if (p != '0) begin
                  tgt_level_in = p;
               end else begin
                  kick_in      = 1'b0;
                  cur_level_in = '0;
                  tgt_level_in = '0;
                  written_in   = 1'b1;
               end
            end else if (p == '0) begin
               cur_level_in = '0;
               tgt_level_in = '0;
               written_in   = 1'b1;
            end else if (p != cur_level_in) begin
               cur_level_in = p;
               tgt_level_in = p;
               written_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_level_ff <= '0;
         tgt_level_ff <= '0;
         kick_ff      <= 1'b0;
         lock_ff      <= 1'b0;
         kick_cnt_ff  <= '0;
         run_cnt_ff   <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         if (xfer) begin
            cur_level_ff <= cur_level_in;
            tgt_level_ff <= tgt_level_in;
            kick_ff      <= kick_in;
            lock_ff      <= lock_in;
            kick_cnt_ff  <= kick_cnt_in;
            run_cnt_ff   <= run_cnt_in;
         end
         if (in_ready) begin
            rsp_vld_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (xfer) begin
         rsp_level_ff   <= cur_level_in;
         rsp_written_ff <= written_in;
         rsp_locked_ff  <= lock_in;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.drive_level   = rsp_level_ff;
   assign rsp_chan.drive_written = rsp_written_ff;
   assign rsp_chan.locked_off    = rsp_locked_ff;

   // The motor is always off while the run-time lockout holds.
   assert property (@(posedge clock) disable iff (reset) lock_ff |-> (cur_level_ff == '0))
      else $error("lockout active with nonzero drive level");

   // A kick never runs while locked off.
   assert property (@(posedge clock) disable iff (reset) kick_ff |-> !lock_ff)
      else $error("kick active during lockout");

   // Any change of the drive level must be reported as a write.
   assert property (@(posedge clock) disable iff (reset)
                    (xfer && cur_level_in != cur_level_ff) |-> written_in)
      else $error("drive level changed without a write");

endmodule

`default_nettype wire

// ----- src/motor_kickstart_power_control_core.sv -----
// Top level of the motor kickstart power control core with run-time cutoff.
// Depends on mkpc_pkg, mkpc_if, mkpc_csr, mkpc_map and mkpc_ctrl.
//
//   Channel    Direction  Handshake           Contents
//   req_chan   in         valid/ready         mode, request
//   rsp_chan   out        valid/ready         drive_level, drive_written, locked_off
//   csr_*      in         csr_wr_en only      register index and write data
//
// One item is taken per cycle while rsp_chan is not stalled; each passes an input register,
// a mapping register (8x8 multiply and divide by 255) and the state update feeding the
// result register, in that order, before its response appears.
// Reset is synchronous and active high; it restores the register defaults and stops the motor.
// A stalled response holds its stage; with the earlier stages full, the stall reaches req_chan.ready in the same cycle.
`default_nettype none

module motor_kickstart_power_control_core
   import mkpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mkpc_req_if.sink                   req_chan,
   mkpc_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type   cfg;
   logic      map_valid;
   logic      map_ready;
   stage_type map_data;

   mkpc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wr_data),
      .cfg      (cfg)
   );

   mkpc_map u_map (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .out_valid (map_valid),
      .out_ready (map_ready),
      .out_data  (map_data)
   );

   mkpc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (map_valid),
      .in_ready (map_ready),
      .in_data  (map_data),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
